// File: hdl/ps2_scancode_to_key_event_fifo_top_defines.svh
// ----------------------------------------------------------------------------
// ps2_scancode_to_key_event_fifo_top_defines.svh
// assertion macros shared by the key event block
// ----------------------------------------------------------------------------
`ifndef PS2_SCANCODE_TO_KEY_EVENT_FIFO_TOP_DEFINES_SVH
`define PS2_SCANCODE_TO_KEY_EVENT_FIFO_TOP_DEFINES_SVH

// same-cycle implication
`define PS2KBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PS2KBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ps2kbd_pkg.sv
// ----------------------------------------------------------------------------
// ps2kbd_pkg
// types, codes and translation tables of the scan code set 1 key event block
// ----------------------------------------------------------------------------
`default_nettype none

package ps2kbd_pkg;

	localparam int unsigned TABLE_LEN = 58;

	localparam logic [7:0] SC_PREFIX     = 8'hE0;
	localparam logic [7:0] SC_BREAK_MASK = 8'h80;
	localparam logic [7:0] SC_KEY_MASK   = 8'h7F;
	localparam logic [7:0] SC_LSHIFT     = 8'h2A;
	localparam logic [7:0] SC_RSHIFT     = 8'h36;
	localparam logic [7:0] SC_CTRL       = 8'h1D;
	localparam logic [7:0] SC_TABLE_LEN  = 8'(TABLE_LEN);

	localparam logic [6:0] CH_BACKSPACE  = 7'd8;
	localparam logic [6:0] CH_TAB        = 7'd9;
	localparam logic [6:0] CH_ENTER      = 7'd10;
	localparam logic [6:0] CH_ESC        = 7'd27;
	localparam logic [6:0] CH_LOWER_A    = 7'h61;
	localparam logic [6:0] CH_LOWER_Z    = 7'h7A;
	localparam logic [6:0] CH_UPPER_A    = 7'h41;
	localparam logic [6:0] CH_UPPER_Z    = 7'h5A;
	localparam logic [6:0] LOWER_OFFSET  = 7'h60;
	localparam logic [6:0] UPPER_OFFSET  = 7'h40;

	typedef enum logic [2:0] {
		KT_CHAR      = 3'd0,
		KT_BACKSPACE = 3'd1,
		KT_ENTER     = 3'd2,
		KT_TAB       = 3'd3,
		KT_ESC       = 3'd4
	} key_type_t;

	typedef struct packed {
		logic       ctrl;
		logic       shift;
		logic [6:0] ch;
		key_type_t  kt;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic   got;
		entry_t entry;
	} result_t;

	localparam logic [6:0] PLAIN_TBL [TABLE_LEN] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
		7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
		7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	localparam logic [6:0] SHIFT_TBL [TABLE_LEN] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
		7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
		7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

endpackage

`default_nettype wire

// File: hdl/ps2kbd_if.sv
// ----------------------------------------------------------------------------
// ps2kbd_if
// command and key event channels, valid/ready with payload
// ----------------------------------------------------------------------------
`default_nettype none

interface ps2kbd_cmd_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] scan_byte;

	modport source (output valid, output action, output scan_byte, input ready);
	modport sink (input valid, input action, input scan_byte, output ready);
endinterface

interface ps2kbd_evt_if;
	logic       valid;
	logic       ready;
	logic       got_key;
	logic [2:0] key_type;
	logic [6:0] char_code;
	logic       shift_held;
	logic       ctrl_held;

	modport source (output valid, output got_key, output key_type, output char_code,
		output shift_held, output ctrl_held, input ready);
	modport sink (input valid, input got_key, input key_type, input char_code,
		input shift_held, input ctrl_held, output ready);
endinterface

`default_nettype wire

// File: hdl/ps2kbd_ram.sv
// ----------------------------------------------------------------------------
// ps2kbd_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ps2kbd_ram #(
	parameter int unsigned WIDTH = 12,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/ps2kbd_decode.sv
// ----------------------------------------------------------------------------
// ps2kbd_decode
// modifier and prefix tracking, table lookup and event classification
// ----------------------------------------------------------------------------
`default_nettype none

module ps2kbd_decode
	import ps2kbd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_en,
	input  wire logic [7:0] scan_byte,
	output      push_t      push
);

	logic       shift_q;
	logic       ctrl_q;
	logic       prefix_q;
	logic       shift_nxt;
	logic       ctrl_nxt;
	logic       prefix_nxt;
	logic [7:0] key;
	logic       in_table;
	logic [5:0] idx;
	logic [6:0] ch_raw;
	logic [6:0] ch;
	key_type_t  kt;

	always_comb begin
		key      = scan_byte & SC_KEY_MASK;
		in_table = (scan_byte < SC_TABLE_LEN);
		idx      = in_table ? scan_byte[5:0] : 6'd0;
		ch_raw   = shift_q ? SHIFT_TBL[idx] : PLAIN_TBL[idx];

		ch = ch_raw;
		if (ctrl_q) begin
			if (ch_raw >= CH_LOWER_A && ch_raw <= CH_LOWER_Z) begin
				ch = ch_raw - LOWER_OFFSET;
			end else if (ch_raw >= CH_UPPER_A && ch_raw <= CH_UPPER_Z) begin
				ch = ch_raw - UPPER_OFFSET;
			end
		end

		unique case (ch)
			CH_BACKSPACE: kt = KT_BACKSPACE;
			CH_ENTER:     kt = KT_ENTER;
			CH_TAB:       kt = KT_TAB;
			CH_ESC:       kt = KT_ESC;
			default:      kt = KT_CHAR;
		endcase

		shift_nxt   = shift_q;
		ctrl_nxt    = ctrl_q;
		prefix_nxt  = prefix_q;
		push.valid  = 1'b0;
		push.entry  = '{ctrl: ctrl_q, shift: shift_q, ch: ch, kt: kt};

		if (byte_en) begin
			if (scan_byte == SC_PREFIX) begin
				prefix_nxt = 1'b1;
			end else if ((scan_byte & SC_BREAK_MASK) != 8'd0) begin
				if (key == SC_LSHIFT || key == SC_RSHIFT) begin
					shift_nxt = 1'b0;
				end
				if (key == SC_CTRL) begin
					ctrl_nxt = 1'b0;
				end
			end else if (prefix_q) begin
				prefix_nxt = 1'b0;
			end else if (scan_byte == SC_LSHIFT || scan_byte == SC_RSHIFT) begin
				shift_nxt = 1'b1;
			end else if (scan_byte == SC_CTRL) begin
				ctrl_nxt = 1'b1;
			end else if (in_table && ch != 7'd0) begin
				push.valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= 1'b0;
			ctrl_q   <= 1'b0;
			prefix_q <= 1'b0;
		end else begin
			shift_q  <= shift_nxt;
			ctrl_q   <= ctrl_nxt;
			prefix_q <= prefix_nxt;
		end
	end

endmodule

`default_nettype wire

// File: hdl/ps2_scancode_to_key_event_fifo_top.sv
// ----------------------------------------------------------------------------
// ps2_scancode_to_key_event_fifo_top
// Scan code set 1 keyboard decoder with a key event ring. Each command beat
// either carries a scan byte (action 0) or asks for one key event (action 1).
// Scan bytes update shift, ctrl and the extended prefix and push decoded
// key events into a ring held in one ram; the ring keeps up to RING_DEPTH-1
// events and drops new ones when full. Every read beat gives exactly one
// event beat, with got_key low and all fields zero when the ring is empty;
// scan byte beats give none. One command beat is taken per clock while the
// event output does not stall; a read's event passes the registered ram read,
// then the output register, and the output register lets the next command
// be taken while an event still waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ps2_scancode_to_key_event_fifo_top_defines.svh"

module ps2_scancode_to_key_event_fifo_top
	import ps2kbd_pkg::*;
#(
	parameter int unsigned RING_DEPTH = 256
) (
	input wire logic     clk,
	input wire logic     arst_n,
	ps2kbd_cmd_if.sink   cmd,
	ps2kbd_evt_if.source evt
);

	localparam int unsigned PW = $clog2(RING_DEPTH);
	localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);

	logic          cmd_fire;
	logic          byte_en;
	logic          rd_en;
	push_t         push;
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW-1:0] wp_next;
	logic [PW-1:0] rp_next;
	logic          empty;
	logic          full;
	logic          do_push;
	logic          do_pop;
	entry_t        rd_entry;
	logic          rd_valid_s1;
	logic          got_s1;
	logic          s1_adv;
	logic          out_valid_q;
	result_t       out_q;

	assign s1_adv    = !out_valid_q || evt.ready;
	assign cmd.ready = !rd_valid_s1 || s1_adv;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign byte_en   = cmd_fire && !cmd.action;
	assign rd_en     = cmd_fire && cmd.action;

	ps2kbd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (byte_en),
		.scan_byte (cmd.scan_byte),
		.push      (push)
	);

	assign wp_next = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
	assign rp_next = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
	assign empty   = (wp_q == rp_q);
	assign full    = (wp_next == rp_q);
	assign do_push = push.valid && !full;
	assign do_pop  = rd_en && !empty;

	ps2kbd_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (do_push),
		.waddr (wp_q),
		.wdata (push.entry),
		.re    (do_pop),
		.raddr (rp_q),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			rd_valid_s1 <= 1'b0;
			got_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_push) begin
				wp_q <= wp_next;
			end
			if (do_pop) begin
				rp_q <= rp_next;
			end
			if (s1_adv || !rd_valid_s1) begin
				rd_valid_s1 <= rd_en;
				got_s1      <= do_pop;
			end
			if (s1_adv) begin
				out_valid_q <= rd_valid_s1;
			end
		end
	end

	// event payload, zeroed on an empty read
	always_ff @(posedge clk) begin
		if (s1_adv && rd_valid_s1) begin
			out_q.got   <= got_s1;
			out_q.entry <= got_s1 ? rd_entry : '0;
		end
	end

	assign evt.valid      = out_valid_q;
	assign evt.got_key    = out_q.got;
	assign evt.key_type   = 3'(out_q.entry.kt);
	assign evt.char_code  = out_q.entry.ch;
	assign evt.shift_held = out_q.entry.shift;
	assign evt.ctrl_held  = out_q.entry.ctrl;

	`PS2KBD_ASSERT_NEXT(a_full_drop, clk, arst_n, push.valid && full, $stable(wp_q), "push into full ring moved write pointer")
	`PS2KBD_ASSERT_NEXT(a_empty_read, clk, arst_n, rd_en && empty, rd_valid_s1 && !got_s1, "empty read did not give a miss")
	`PS2KBD_ASSERT_NEXT(a_s1_hold, clk, arst_n, rd_valid_s1 && !s1_adv, rd_valid_s1 && $stable(got_s1), "stalled read stage lost its beat")

endmodule

`default_nettype wire

// File: tb/sv/ps2_scancode_to_key_event_fifo_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_scancode_to_key_event_fifo_top_tb
// Self-checking bench for the scan code set 1 key event block. Scan byte and
// read beats go in through a bursty driver; a monitor keeps its own copy of
// the modifier flags, the prefix flag and the event ring. For every read beat
// it queues the key event it expects, and checks each event beat against it
// field by field. The receiver stalls on a changing pattern of its own.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_scancode_to_key_event_fifo_top_tb;
	import ps2kbd_pkg::*;

	localparam int unsigned RING_DEPTH  = 256;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          MAP_LEN     = 58;

	localparam logic ACT_SCAN = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam logic [7:0] SCAN_EXT    = 8'hE0;
	localparam logic [7:0] BREAK_BIT   = 8'h80;
	localparam logic [7:0] SCAN_LSHIFT = 8'h2A;
	localparam logic [7:0] SCAN_RSHIFT = 8'h36;
	localparam logic [7:0] SCAN_CTRL   = 8'h1D;
	localparam logic [7:0] KEY_ESC     = 8'h01;
	localparam logic [7:0] KEY_Q       = 8'h10;
	localparam logic [7:0] KEY_I       = 8'h17;
	localparam logic [7:0] KEY_P       = 8'h19;
	localparam logic [7:0] KEY_A       = 8'h1E;
	localparam logic [7:0] KEY_H       = 8'h23;
	localparam logic [7:0] KEY_J       = 8'h24;
	localparam logic [7:0] KEY_SLASH   = 8'h35;
	localparam logic [7:0] KEY_SPACE   = 8'h39;
	localparam logic [7:0] KEY_CAPS    = 8'h3A;
	localparam logic [7:0] KEY_TOP     = 8'h7F;

	localparam logic [6:0] CHAR_BS    = 7'd8;
	localparam logic [6:0] CHAR_TAB   = 7'd9;
	localparam logic [6:0] CHAR_LF    = 7'd10;
	localparam logic [6:0] CHAR_ESC   = 7'd27;

	localparam logic [6:0] PLAIN_MAP [MAP_LEN] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
		7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
		7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	localparam logic [6:0] SHIFTED_MAP [MAP_LEN] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
		7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
		7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	typedef struct packed {
		logic       got;
		key_type_t  kt;
		logic [6:0] ch;
		logic       shift;
		logic       ctrl;
	} kbd_evt_t;

	typedef struct packed {
		logic       hold;
		logic       action;
		logic [7:0] scan;
	} cmd_item_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_CHOKE,
		RX_EVERY_THIRD
	} rx_mode_t;

	logic clk;
	logic arst_n;

	ps2kbd_cmd_if cmd ();
	ps2kbd_evt_if evt ();

	ps2_scancode_to_key_event_fifo_top #(
		.RING_DEPTH(RING_DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.evt   (evt)
	);

	// decoder model state
	logic        shift_on;
	logic        ctrl_on;
	logic        prefix_pending;
	kbd_evt_t    key_ring [RING_DEPTH];
	int unsigned ring_wr;
	int unsigned ring_rd;

	kbd_evt_t    expected_events [$];
	cmd_item_t   pending_cmds [$];
	cmd_item_t   next_cmd;
	kbd_evt_t    want_event;
	int          in_flight = 0;
	int          mismatches = 0;
	int          cycle_count = 0;
	int          burst_left;
	int          gap_left;
	rx_mode_t    rx_mode;
	logic [5:0]  rx_tick;

	function automatic void decode_scan_byte(logic [7:0] sc);
		logic [6:0]  ch;
		key_type_t   kt;
		int unsigned nxt;
		if (sc == SCAN_EXT) begin
			prefix_pending = 1'b1;
		end else if ((sc & BREAK_BIT) != 8'h00) begin
			// break leaves the prefix flag alone
			if ((sc & ~BREAK_BIT) == SCAN_LSHIFT || (sc & ~BREAK_BIT) == SCAN_RSHIFT)
				shift_on = 1'b0;
			if ((sc & ~BREAK_BIT) == SCAN_CTRL)
				ctrl_on = 1'b0;
		end else if (prefix_pending) begin
			prefix_pending = 1'b0;
		end else if (sc == SCAN_LSHIFT || sc == SCAN_RSHIFT) begin
			shift_on = 1'b1;
		end else if (sc == SCAN_CTRL) begin
			ctrl_on = 1'b1;
		end else if (sc < MAP_LEN) begin
			ch = shift_on ? SHIFTED_MAP[sc] : PLAIN_MAP[sc];
			if (ctrl_on && ch inside {[7'h61:7'h7A]})
				ch = ch - 7'h60;
			else if (ctrl_on && ch inside {[7'h41:7'h5A]})
				ch = ch - 7'h40;
			if (ch != 7'd0) begin
				case (ch)
					CHAR_BS: kt = KT_BACKSPACE;
					CHAR_LF: kt = KT_ENTER;
					CHAR_TAB: kt = KT_TAB;
					CHAR_ESC: kt = KT_ESC;
					default: kt = KT_CHAR;
				endcase
				nxt = (ring_wr + 1) % RING_DEPTH;
				// full ring drops the new event
				if (nxt != ring_rd) begin
					key_ring[ring_wr] = '{got: 1'b1, kt: kt, ch: ch, shift: shift_on,
						ctrl: ctrl_on};
					ring_wr = nxt;
				end
			end
		end
	endfunction

	function automatic kbd_evt_t take_key_event();
		kbd_evt_t ev;
		if (ring_wr == ring_rd) begin
			ev = '{got: 1'b0, kt: KT_CHAR, ch: 7'd0, shift: 1'b0, ctrl: 1'b0};
		end else begin
			ev = key_ring[ring_rd];
			ring_rd = (ring_rd + 1) % RING_DEPTH;
		end
		return ev;
	endfunction

	task automatic check_field(string field, logic [7:0] want, logic [7:0] seen);
		if (want !== seen) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
			mismatches++;
		end
	endtask

	function automatic void queue_scan(logic [7:0] b);
		pending_cmds.push_back('{hold: 1'b0, action: ACT_SCAN, scan: b});
	endfunction

	function automatic void queue_read();
		pending_cmds.push_back('{hold: 1'b0, action: ACT_READ, scan: 8'($urandom_range(0, 255))});
	endfunction

	function automatic void queue_hold();
		pending_cmds.push_back('{hold: 1'b1, action: ACT_SCAN, scan: 8'h00});
	endfunction

	function automatic void queue_random_sequence();
		int         pick;
		int         n;
		logic [7:0] k;
		logic [7:0] shift_key;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			// typed keys with optional modifiers
			shift_key = $urandom_range(0, 1) ? SCAN_RSHIFT : SCAN_LSHIFT;
			n = $urandom_range(0, 3);
			if (n[0])
				queue_scan(shift_key);
			if (n[1])
				queue_scan(SCAN_CTRL);
			repeat ($urandom_range(1, 4)) begin
				k = 8'($urandom_range(0, MAP_LEN - 1));
				queue_scan(k);
				if ($urandom_range(0, 1))
					queue_scan(k | BREAK_BIT);
			end
			if (n[0] && $urandom_range(0, 4) != 0)
				queue_scan(shift_key | BREAK_BIT);
			if (n[1] && $urandom_range(0, 4) != 0)
				queue_scan(SCAN_CTRL | BREAK_BIT);
		end else if (pick < 75) begin
			repeat ($urandom_range(1, 5))
				queue_read();
		end else if (pick < 85) begin
			// extended key, sometimes with the break first
			k = 8'($urandom_range(0, 127));
			queue_scan(SCAN_EXT);
			if ($urandom_range(0, 2) == 0) begin
				queue_scan(k | BREAK_BIT);
				queue_scan(k & ~BREAK_BIT);
			end else begin
				queue_scan(k);
				queue_scan(SCAN_EXT);
				queue_scan(k | BREAK_BIT);
			end
		end else if (pick < 92) begin
			queue_scan(8'($urandom_range(MAP_LEN, 127)));
		end else begin
			queue_scan(8'($urandom_range(0, 255)));
		end
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.action = ACT_SCAN;
		cmd.scan_byte = 8'h00;
		evt.ready = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		int base;
		shift_on = 1'b0;
		ctrl_on = 1'b0;
		prefix_pending = 1'b0;
		ring_wr = 0;
		ring_rd = 0;

		// directed: empty read, table zero, modifiers, ctrl letters, prefix cases
		queue_read();
		queue_scan(8'h00);
		queue_scan(KEY_A);
		queue_scan(SCAN_LSHIFT);
		queue_scan(KEY_Q);
		queue_scan(SCAN_LSHIFT | BREAK_BIT);
		queue_scan(SCAN_CTRL);
		queue_scan(KEY_H);
		queue_scan(KEY_I);
		queue_scan(KEY_J);
		queue_scan(SCAN_CTRL | BREAK_BIT);
		queue_scan(KEY_ESC);
		queue_scan(SCAN_EXT);
		queue_scan(KEY_A);
		queue_scan(SCAN_EXT);
		queue_scan(KEY_A | BREAK_BIT);
		queue_scan(KEY_A);
		queue_scan(SCAN_EXT);
		queue_scan(SCAN_LSHIFT);
		queue_scan(KEY_CAPS);
		queue_scan(KEY_TOP);
		queue_scan(SCAN_RSHIFT);
		queue_scan(KEY_SLASH);
		queue_scan(KEY_SPACE);
		queue_scan(8'hFF);
		queue_scan(SCAN_RSHIFT | BREAK_BIT);
		repeat (9)
			queue_read();
		queue_hold();

		base = pending_cmds.size();
		while (pending_cmds.size() - base < 880)
			queue_random_sequence();
		queue_hold();

		// flood past the ring capacity, then drain it
		queue_scan(SCAN_LSHIFT | BREAK_BIT);
		queue_scan(SCAN_RSHIFT | BREAK_BIT);
		queue_scan(SCAN_CTRL | BREAK_BIT);
		repeat (270)
			queue_scan(8'($urandom_range(KEY_Q, KEY_P)));
		repeat (262)
			queue_read();

		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || cmd.valid || in_flight != 0);
		repeat (8) @(negedge clk);
		if (mismatches == 0 && expected_events.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// driver: bursts of beats with random gaps, holds drain the pipeline
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			cmd.action <= ACT_SCAN;
			cmd.scan_byte <= 8'h00;
			burst_left <= 1;
			gap_left <= 0;
		end else if (!cmd.valid || cmd.ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				cmd.valid <= 1'b0;
			end else if (pending_cmds.size() != 0 && pending_cmds[0].hold) begin
				cmd.valid <= 1'b0;
				if (!cmd.valid && in_flight == 0)
					void'(pending_cmds.pop_front());
			end else if (pending_cmds.size() != 0) begin
				next_cmd = pending_cmds.pop_front();
				cmd.valid <= 1'b1;
				cmd.action <= next_cmd.action;
				cmd.scan_byte <= next_cmd.scan;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				cmd.valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, mode changes each time the tick counter wraps
	always @(posedge clk) begin
		if (!arst_n) begin
			evt.ready <= 1'b0;
			rx_mode <= RX_OPEN;
			rx_tick <= 6'd0;
		end else begin
			rx_tick <= rx_tick + 6'd1;
			if (rx_tick == 6'd0)
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_OPEN: evt.ready <= 1'b1;
				RX_COIN: evt.ready <= 1'($urandom_range(0, 1));
				RX_CHOKE: evt.ready <= ($urandom_range(0, 3) == 0);
				RX_EVERY_THIRD: evt.ready <= (rx_tick % 3 != 0);
			endcase
		end
	end

	// monitor: model update on command beats, check on event beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd.valid && cmd.ready) begin
				if (cmd.action == ACT_READ)
					expected_events.push_back(take_key_event());
				else
					decode_scan_byte(cmd.scan_byte);
			end
			if (evt.valid && evt.ready) begin
				if (expected_events.size() == 0) begin
					$display("%0t ns: unexpected event beat, expected none, actual %0h %0h %0h %0h %0h",
						$time, evt.got_key, evt.key_type, evt.char_code, evt.shift_held,
						evt.ctrl_held);
					mismatches++;
				end else begin
					want_event = expected_events.pop_front();
					check_field("got_key", 8'(want_event.got), 8'(evt.got_key));
					check_field("key_type", 8'(want_event.kt), 8'(evt.key_type));
					check_field("char_code", 8'(want_event.ch), 8'(evt.char_code));
					check_field("shift_held", 8'(want_event.shift), 8'(evt.shift_held));
					check_field("ctrl_held", 8'(want_event.ctrl), 8'(evt.ctrl_held));
				end
			end
			in_flight <= in_flight + int'(cmd.valid && cmd.ready && cmd.action == ACT_READ)
				- int'(evt.valid && evt.ready);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hdl
hdl/ps2kbd_pkg.sv
hdl/ps2kbd_if.sv
hdl/ps2kbd_ram.sv
hdl/ps2kbd_decode.sv
hdl/ps2_scancode_to_key_event_fifo_top.sv
tb/sv/ps2_scancode_to_key_event_fifo_top_tb.sv
